// ===== src/canarb_pkg.sv =====
// ----------------------------------------------------------------------------
// canarb_pkg
// Shared types, codes and helpers for the lowest-identifier bus arbiter:
// request and response beats, slot status codes, the per-cell command and
// the arbitration carry that travels down the cell row.
// ----------------------------------------------------------------------------
package canarb_pkg;

   // Default slot count
   localparam int NODES_DEFAULT = 8;

   // Field widths
   localparam int OP_W     = 2;
   localparam int NODE_W   = 3;
   localparam int ID_W     = 11;
   localparam int LEN_W    = 4;
   localparam int DATA_W   = 64;
   localparam int TRIES_W  = 6;
   localparam int MASK_W   = 8;
   localparam int CSR_IDX_W = 1;

   // Limits
   localparam int MAX_LEN   = 8;
   localparam int MAX_TRIES = 63;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_SEND = 2'd0,
      OP_TICK = 2'd1,
      OP_POLL = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BUSY     = 2'd1,
      STATUS_DETACHED = 2'd2
   } status_type;

   // Transmit outcome reported on poll
   typedef enum logic [1:0] {
      TXE_NONE  = 2'd0,
      TXE_DONE  = 2'd1,
      TXE_FAULT = 2'd2
   } tx_event_type;

   // Transmit slot status
   typedef enum logic [1:0] {
      SLOT_EMPTY    = 2'd0,
      SLOT_TRANSMIT = 2'd1,
      SLOT_REFUSED  = 2'd2,
      SLOT_COMPLETE = 2'd3
   } slot_status_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ATTACH_MASK = 1'b0,
      REG_RETRY_LIMIT = 1'b1
   } csr_reg_type;

   // Request beat
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [NODE_W-1:0] node;
      logic [ID_W-1:0]   frame_id;
      logic [LEN_W-1:0]  frame_len;
      logic [DATA_W-1:0] payload;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [1:0]        status;
      logic [1:0]        tx_event;
      logic              rx_valid;
      logic [ID_W-1:0]   rx_id;
      logic [LEN_W-1:0]  rx_len;
      logic [DATA_W-1:0] rx_data;
      logic              tx_ready;
      logic              granted;
      logic [NODE_W-1:0] granted_node;
   } rsp_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic               send;
      logic               poll;
      logic               rebuild;
      logic               commit;
      logic [NODE_W-1:0]  node;
      logic [ID_W-1:0]    frame_id;
      logic [LEN_W-1:0]   frame_len;
      logic [DATA_W-1:0]  payload;
      logic [TRIES_W-1:0] tries;
      logic [MASK_W-1:0]  attach_mask;
      logic [MASK_W-1:0]  snap_mask;
   } cmd_type;

   // Running arbitration winner handed from cell to cell
   typedef struct packed {
      logic              have;
      logic [ID_W-1:0]   id;
      logic [NODE_W-1:0] node;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] data;
   } carry_type;

   // Slot view exported by one cell
   typedef struct packed {
      slot_status_type state;
      logic            rx_pending;
   } slot_type;

   // Slot view of the addressed node
   typedef struct packed {
      logic     hit;
      slot_type slot;
   } sel_type;

   // Length clamped to eight bytes
   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
      return (len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len;
   endfunction

   // Zero every payload byte at or past the length
   function automatic logic [DATA_W-1:0] frame_bytes(input logic [DATA_W-1:0] data,
                                                     input logic [LEN_W-1:0]  len);
      logic [DATA_W-1:0] keep;
      keep = '0;
      for (int b = 0; b < DATA_W / 8; b++) begin
         if (LEN_W'(b) < len) begin
            keep[b*8 +: 8] = 8'hFF;
         end
      end
      return data & keep;
   endfunction

   // Try budget: retry limit plus one, clamped
   function automatic logic [TRIES_W-1:0] try_budget(input logic [TRIES_W-1:0] retry);
      return (retry == TRIES_W'(MAX_TRIES)) ? retry : retry + TRIES_W'(1);
   endfunction

endpackage

// ===== src/canarb_cell.sv =====
// ----------------------------------------------------------------------------
// canarb_cell
// One transmit slot of the bus. Holds the slot frame, try count and receive
// flag, and takes one arbitration step when the sweep token reaches it,
// passing the running winner on to the next cell.
// ----------------------------------------------------------------------------
module canarb_cell #(
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  canarb_pkg::cmd_type   cmd,
   input  logic                 token_in,
   input  canarb_pkg::carry_type carry_in,
   output logic                 token_out,
   output canarb_pkg::carry_type carry_out,
   output canarb_pkg::slot_type  slot
);

   // Only the first eight slots can ever be attached
   localparam bit ATTACHABLE = (INDEX < canarb_pkg::MASK_W);
   localparam logic [canarb_pkg::NODE_W-1:0] NODE_CODE =
      canarb_pkg::NODE_W'(INDEX % canarb_pkg::MASK_W);

   canarb_pkg::slot_status_type        state_ff, state_in;
   logic [canarb_pkg::TRIES_W-1:0]     tries_ff, tries_in;
   logic [canarb_pkg::ID_W-1:0]        id_ff, id_in;
   logic [canarb_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [canarb_pkg::DATA_W-1:0]      data_ff, data_in;
   logic                               rx_ff, rx_in;
   logic                               token_ff;
   canarb_pkg::carry_type              carry_ff, carry_in_nx;

   logic hit;
   logic attach_bit;
   logic snap_bit;
   logic eligible;

   assign hit        = ATTACHABLE && (cmd.node == NODE_CODE);
   assign attach_bit = ATTACHABLE && cmd.attach_mask[NODE_CODE];
   assign snap_bit   = ATTACHABLE && cmd.snap_mask[NODE_CODE];

   // Slot update for send, poll, rebuild, sweep step and commit
   always_comb begin
      state_in    = state_ff;
      tries_in    = tries_ff;
      id_in       = id_ff;
      len_in      = len_ff;
      data_in     = data_ff;
      rx_in       = rx_ff;
      eligible    = 1'b0;
      carry_in_nx = carry_in;

      if (cmd.send && hit) begin
         state_in = canarb_pkg::SLOT_TRANSMIT;
         tries_in = cmd.tries;
         id_in    = cmd.frame_id;
         len_in   = cmd.frame_len;
         data_in  = cmd.payload;
      end

      if (cmd.poll && hit) begin
         if (state_ff == canarb_pkg::SLOT_REFUSED || state_ff == canarb_pkg::SLOT_COMPLETE) begin
            state_in = canarb_pkg::SLOT_EMPTY;
         end
         rx_in = 1'b0;
      end

      if (cmd.rebuild && attach_bit && state_ff != canarb_pkg::SLOT_EMPTY) begin
         state_in = canarb_pkg::SLOT_REFUSED;
      end

      // Arbitration step: spend a try or give up
      if (token_in && snap_bit && state_ff == canarb_pkg::SLOT_TRANSMIT) begin
         if (tries_ff != '0) begin
            tries_in = tries_ff - canarb_pkg::TRIES_W'(1);
            eligible = 1'b1;
         end else begin
            state_in = canarb_pkg::SLOT_REFUSED;
         end
      end

      // Strictly lower id wins, so the earlier cell keeps a tie
      if (eligible && (!carry_in.have || id_ff < carry_in.id)) begin
         carry_in_nx.have = 1'b1;
         carry_in_nx.id   = id_ff;
         carry_in_nx.node = NODE_CODE;
         carry_in_nx.len  = len_ff;
         carry_in_nx.data = data_ff;
      end

      if (cmd.commit) begin
         if (snap_bit) begin
            rx_in = 1'b1;
         end
         if (hit) begin
            state_in = canarb_pkg::SLOT_COMPLETE;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= canarb_pkg::SLOT_EMPTY;
         tries_ff <= '0;
         rx_ff    <= 1'b0;
         token_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tries_ff <= tries_in;
         rx_ff    <= rx_in;
         token_ff <= token_in;
      end
   end

   // Frame storage and carry
   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      len_ff   <= len_in;
      data_ff  <= data_in;
      carry_ff <= carry_in_nx;
   end

   assign token_out       = token_ff;
   assign carry_out       = carry_ff;
   assign slot.state      = state_ff;
   assign slot.rx_pending = rx_ff;

endmodule

// ===== src/canarb_row.sv =====
// ----------------------------------------------------------------------------
// canarb_row
// The row of slot cells with the sweep token and winner carry chained from
// cell to cell, plus the read mux for the addressed node.
// ----------------------------------------------------------------------------
module canarb_row #(
   parameter int NODES = canarb_pkg::NODES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  canarb_pkg::cmd_type                cmd,
   input  logic                              start,
   input  logic [canarb_pkg::NODE_W-1:0]     sel_node,
   output canarb_pkg::sel_type                sel,
   output logic                              tail_token,
   output canarb_pkg::carry_type              tail_carry
);

   logic                  tok   [NODES+1];
   canarb_pkg::carry_type carry [NODES+1];
   canarb_pkg::slot_type  slots [NODES];

   assign tok[0]   = start;
   assign carry[0] = '0;

   // Cell chain
   for (genvar i = 0; i < NODES; i++) begin : g_cell
      canarb_cell #(
         .INDEX(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .token_in  (tok[i]),
         .carry_in  (carry[i]),
         .token_out (tok[i+1]),
         .carry_out (carry[i+1]),
         .slot      (slots[i])
      );
   end

   assign tail_token = tok[NODES];
   assign tail_carry = carry[NODES];

   // Addressed slot view; no hit for a node past the row
   always_comb begin
      sel = '0;
      for (int i = 0; i < NODES; i++) begin
         if (i < canarb_pkg::MASK_W && sel_node == canarb_pkg::NODE_W'(i)) begin
            sel.hit  = 1'b1;
            sel.slot = slots[i];
         end
      end
   end

endmodule

// ===== src/can_bus_lowest_id_arbiter_top.sv =====
// ----------------------------------------------------------------------------
// can_bus_lowest_id_arbiter_top
// Shared bus with NODES transmit slots and lowest-identifier arbitration.
// Sends, polls and ticks are decoded here; the slots live in a row of cells
// that a tick sweeps one cell per cycle.
//
//   channel  dir  handshake            beat
//   req_     in   req_valid/req_stall  canarb_pkg::req_type
//   rsp_     out  rsp_valid/rsp_stall  canarb_pkg::rsp_type
//   csr_     in   csr_write_en         csr_index, csr_wdata
//
// Send, poll and unused op go from idle straight to finish before the next accept.
// A tick after an attach mask change does the same; other ticks sweep first,
// waiting for the sweep token walking the cell row one cell per cycle.
// Reset is synchronous; no clearing pass, the block is ready right away.
// A response waits in the output register while rsp_stall is high; the next
// request is taken meanwhile and held before its result is loaded.
// ----------------------------------------------------------------------------
module can_bus_lowest_id_arbiter_top #(
   parameter int NODES = canarb_pkg::NODES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  canarb_pkg::req_type                  req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output canarb_pkg::rsp_type                  rsp_payload,
   input  logic                                csr_write_en,
   input  logic [canarb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [canarb_pkg::MASK_W-1:0]       csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SWEEP  = 3'b010,
      ST_FINISH = 3'b100
   } fsm_type;

   fsm_type                          state_ff, state_in;
   logic [canarb_pkg::MASK_W-1:0]    mask_ff, mask_in;
   logic [canarb_pkg::TRIES_W-1:0]   retry_ff, retry_in;
   logic [canarb_pkg::MASK_W-1:0]    snap_ff, snap_in;
   logic                             rebuild_ff, rebuild_in;
   logic [canarb_pkg::ID_W-1:0]      last_id_ff, last_id_in;
   logic [canarb_pkg::LEN_W-1:0]     last_len_ff, last_len_in;
   logic [canarb_pkg::DATA_W-1:0]    last_data_ff, last_data_in;
   logic [canarb_pkg::NODE_W-1:0]    node_ff, node_in;
   canarb_pkg::rsp_type              pend_ff, pend_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   canarb_pkg::rsp_type              rsp_ff, rsp_in;

   canarb_pkg::cmd_type              cmd;
   canarb_pkg::sel_type              sel;
   canarb_pkg::carry_type            tail_carry;
   logic                             tail_token;
   logic                             start;
   logic                             rsp_load;
   logic                             req_accept;
   logic                             attached;
   logic [canarb_pkg::NODE_W-1:0]    sel_node;
   logic [canarb_pkg::LEN_W-1:0]     len_sat;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign sel_node   = (state_ff == ST_IDLE) ? req_payload.node : node_ff;
   assign attached   = sel.hit && mask_ff[req_payload.node];
   assign len_sat    = canarb_pkg::sat_len(req_payload.frame_len);

   canarb_row #(
      .NODES(NODES)
   ) u_row (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .start      (start),
      .sel_node   (sel_node),
      .sel        (sel),
      .tail_token (tail_token),
      .tail_carry (tail_carry)
   );

   // Sequencer: decode on accept, wait for the sweep, then load the response
   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      retry_in     = retry_ff;
      snap_in      = snap_ff;
      rebuild_in   = rebuild_ff;
      last_id_in   = last_id_ff;
      last_len_in  = last_len_ff;
      last_data_in = last_data_ff;
      node_in      = node_ff;
      pend_in      = pend_ff;
      start        = 1'b0;
      rsp_load     = 1'b0;

      cmd             = '0;
      cmd.node        = req_payload.node;
      cmd.frame_id    = req_payload.frame_id;
      cmd.frame_len   = len_sat;
      cmd.payload     = canarb_pkg::frame_bytes(req_payload.payload, len_sat);
      cmd.tries       = canarb_pkg::try_budget(retry_ff);
      cmd.attach_mask = mask_ff;
      cmd.snap_mask   = snap_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               node_in  = req_payload.node;
               pend_in  = '0;
               state_in = ST_FINISH;
               unique case (canarb_pkg::op_type'(req_payload.op))
                  canarb_pkg::OP_SEND: begin
                     if (!attached) begin
                        pend_in.status = canarb_pkg::STATUS_DETACHED;
                     end else if (sel.slot.state != canarb_pkg::SLOT_EMPTY) begin
                        pend_in.status = canarb_pkg::STATUS_BUSY;
                     end else begin
                        cmd.send = 1'b1;
                     end
                  end
                  canarb_pkg::OP_TICK: begin
                     if (rebuild_ff) begin
                        cmd.rebuild = 1'b1;
                        snap_in     = mask_ff;
                        rebuild_in  = 1'b0;
                     end else begin
                        start    = 1'b1;
                        state_in = ST_SWEEP;
                     end
                  end
                  canarb_pkg::OP_POLL: begin
                     if (!attached) begin
                        pend_in.status = canarb_pkg::STATUS_DETACHED;
                     end else begin
                        cmd.poll = 1'b1;
                        if (sel.slot.state == canarb_pkg::SLOT_REFUSED) begin
                           pend_in.tx_event = canarb_pkg::TXE_FAULT;
                        end else if (sel.slot.state == canarb_pkg::SLOT_COMPLETE) begin
                           pend_in.tx_event = canarb_pkg::TXE_DONE;
                        end
                        if (sel.slot.rx_pending) begin
                           pend_in.rx_valid = 1'b1;
                           pend_in.rx_id    = last_id_ff;
                           pend_in.rx_len   = last_len_ff;
                           pend_in.rx_data  = last_data_ff;
                        end
                     end
                  end
                  canarb_pkg::OP_NONE: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            // Winner leaves the last cell: latch bus frame, mark complete
            if (tail_token) begin
               state_in = ST_FINISH;
               if (tail_carry.have) begin
                  cmd.commit           = 1'b1;
                  cmd.node             = tail_carry.node;
                  last_id_in           = tail_carry.id;
                  last_len_in          = tail_carry.len;
                  last_data_in         = tail_carry.data;
                  pend_in.granted      = 1'b1;
                  pend_in.granted_node = tail_carry.node;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes
      if (csr_write_en) begin
         unique case (canarb_pkg::csr_reg_type'(csr_index))
            canarb_pkg::REG_ATTACH_MASK: begin
               if (csr_wdata != mask_ff) begin
                  mask_in    = csr_wdata;
                  rebuild_in = 1'b1;
               end
            end
            canarb_pkg::REG_RETRY_LIMIT: begin
               retry_in = csr_wdata[canarb_pkg::TRIES_W-1:0];
            end
         endcase
      end
   end

   // Output register
   always_comb begin
      rsp_in          = pend_ff;
      rsp_in.tx_ready = sel.hit && (sel.slot.state == canarb_pkg::SLOT_EMPTY);
      rsp_valid_in    = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         retry_ff     <= '0;
         snap_ff      <= '0;
         rebuild_ff   <= 1'b1;
         last_id_ff   <= '0;
         last_len_ff  <= '0;
         last_data_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         retry_ff     <= retry_in;
         snap_ff      <= snap_in;
         rebuild_ff   <= rebuild_in;
         last_id_ff   <= last_id_in;
         last_len_ff  <= last_len_in;
         last_data_ff <= last_data_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Beat payload
   always_ff @(posedge clock) begin
      node_ff <= node_in;
      pend_ff <= pend_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== src/canarb_checker.sv =====
// ----------------------------------------------------------------------------
// canarb_checker
// Port-level checks for the arbiter, bound to the top level.
// ----------------------------------------------------------------------------
module canarb_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input canarb_pkg::rsp_type rsp_payload
);

   // Stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   // One request in flight: the cycle after an accept is stalled
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

   // Receive fields are zero unless a frame is delivered
   a_rx_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.rx_valid |->
         rsp_payload.rx_id == '0 && rsp_payload.rx_len == '0 && rsp_payload.rx_data == '0)
      else $error("receive fields set without a delivered frame");

   // Grant node is zero without a grant, and a grant never reports a poll outcome
   a_grant_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_payload.granted && rsp_payload.granted_node != '0 ||
                    rsp_payload.granted && (rsp_payload.tx_event != '0 ||
                                            rsp_payload.rx_valid)) |-> 1'b0)
      else $error("grant fields inconsistent");

   // Delivered length never exceeds eight bytes
   a_rx_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.rx_valid |->
         rsp_payload.rx_len <= canarb_pkg::LEN_W'(canarb_pkg::MAX_LEN))
      else $error("delivered length out of range");

endmodule

bind can_bus_lowest_id_arbiter_top canarb_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
